### hdl/ael_pkg.sv
// shared types, token codes, character codes and keyword tables of the expression lexer
package ael_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int KIND_W          = 5;
    localparam int TOKEN_VALUE_W   = 32;
    localparam int OUT_TDATA_W     = 48;
    localparam int QUEUE_DEPTH     = 4;
    localparam int KW_COUNT        = 6;

    // token kinds
    localparam logic [KIND_W-1:0] TK_NUMBER  = 5'd0;
    localparam logic [KIND_W-1:0] TK_PLUS    = 5'd1;
    localparam logic [KIND_W-1:0] TK_MINUS   = 5'd2;
    localparam logic [KIND_W-1:0] TK_MUL     = 5'd3;
    localparam logic [KIND_W-1:0] TK_DIV     = 5'd4;
    localparam logic [KIND_W-1:0] TK_POW     = 5'd5;
    localparam logic [KIND_W-1:0] TK_LPAREN  = 5'd6;
    localparam logic [KIND_W-1:0] TK_RPAREN  = 5'd7;
    localparam logic [KIND_W-1:0] TK_SIN     = 5'd8;
    localparam logic [KIND_W-1:0] TK_COS     = 5'd9;
    localparam logic [KIND_W-1:0] TK_TAN     = 5'd10;
    localparam logic [KIND_W-1:0] TK_SQRT    = 5'd11;
    localparam logic [KIND_W-1:0] TK_LOG     = 5'd12;
    localparam logic [KIND_W-1:0] TK_LOGBASE = 5'd13;
    localparam logic [KIND_W-1:0] TK_ABS     = 5'd14;
    localparam logic [KIND_W-1:0] TK_UNKNOWN = 5'd15;
    localparam logic [KIND_W-1:0] TK_END     = 5'd16;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NONE   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C      = 8'h63;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_S      = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;

    // keyword spelling, length and kind
    localparam logic [CHAR_W-1:0] KW_TEXT [KW_COUNT][4] = '{
        '{"s", "i", "n", 8'h00},
        '{"c", "o", "s", 8'h00},
        '{"t", "a", "n", 8'h00},
        '{"s", "q", "r", "t"},
        '{"l", "o", "g", 8'h00},
        '{"a", "b", "s", 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3};
    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] =
        '{TK_SIN, TK_COS, TK_TAN, TK_SQRT, TK_LOG, TK_ABS};

    localparam logic [2:0] MAX_RESULTS = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [TOKEN_VALUE_W-1:0] value;
        logic                     neg;
        logic                     ovf;
        logic [CHAR_W-1:0]        uchar;
        logic                     last;
    } t_token;

    function automatic logic is_kw_start(input logic [CHAR_W-1:0] c);
        return c == CH_S || c == CH_C || c == CH_T || c == CH_A || c == CH_L;
    endfunction

endpackage

### hdl/ael_front.sv
// lexer front end: takes characters, classifies them and produces at most one token a cycle while the queue is not full
module ael_front #(
    parameter int VALUE_WIDTH = ael_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ael_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    output logic                        o_ready,
    input  logic                        i_q_full,
    output logic                        o_push,
    output ael_pkg::t_token             o_token
);
    import ael_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHAR  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [3:0][CHAR_W-1:0]      r_pend, n_pend;
    logic [2:0]                  r_pcnt, n_pcnt;
    logic                        r_last, n_last;
    logic [VALUE_WIDTH-1:0]      r_mag, n_mag;
    logic                        r_neg, n_neg;
    logic                        r_ovf, n_ovf;
    logic                        r_num_open, n_num_open;
    logic                        r_minus, n_minus;
    logic [2:0][CHAR_W-1:0]      r_buf, n_buf;
    logic [1:0]                  r_held, n_held;
    logic                        r_log, n_log;
    logic                        r_base, n_base;
    logic [CHAR_W-1:0]           r_prior, n_prior;
    logic                        r_closed, n_closed;
    logic                        r_mul_done, n_mul_done;
    logic [2:0]                  r_ecnt, n_ecnt;

    logic [CHAR_W-1:0]           c;
    logic                        digit;
    logic [3:0]                  dval;
    logic                        close_any;
    logic                        do_close;
    logic                        finish;
    logic                        emit;
    logic [KIND_W-1:0]           e_kind;
    logic [VALUE_WIDTH-1:0]      e_value;
    logic                        e_neg;
    logic                        e_ovf;
    logic [CHAR_W-1:0]           e_uchar;
    logic                        e_last;
    logic [VALUE_WIDTH:0]        acc;
    logic [3:0][CHAR_W-1:0]      kb;
    logic [2:0]                  kn;
    logic                        kw_hit;
    logic                        kw_pref;
    logic [KIND_W-1:0]           kw_kind;
    logic [1:0]                  h1;

    // saturating decimal step: mag*10 + d by shift and add, msb of result is overflow
    function automatic logic [VALUE_WIDTH:0] acc_step(input logic [VALUE_WIDTH-1:0] mag,
                                                      input logic [3:0] d);
        logic [VALUE_WIDTH+3:0] wide;
        logic [VALUE_WIDTH:0]   res;
        wide = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + (VALUE_WIDTH+4)'(d);
        if (wide[VALUE_WIDTH+3:VALUE_WIDTH] != 4'b0) begin
            res = {1'b1, {VALUE_WIDTH{1'b1}}};
        end else begin
            res = {1'b0, wide[VALUE_WIDTH-1:0]};
        end
        return res;
    endfunction

    assign c         = r_pend[0];
    assign digit     = (c >= CH_ZERO) && (c <= CH_NINE);
    assign dval      = 4'(c - CH_ZERO);
    assign close_any = r_minus || r_num_open || r_base || r_log;
    assign acc       = acc_step(r_mag, dval);
    assign o_ready   = (r_state == ST_IDLE);
    assign h1        = r_held - 2'd1;

    // held letters plus the new one against every keyword
    always_comb begin
        logic same;
        kw_hit  = 1'b0;
        kw_pref = 1'b0;
        kw_kind = TK_UNKNOWN;
        kn      = 3'(r_held) + 3'd1;
        for (int i = 0; i < 3; i++) begin
            if (i < int'(r_held)) begin
                kb[i] = r_buf[i];
            end else if (i == int'(r_held)) begin
                kb[i] = c;
            end else begin
                kb[i] = CH_NONE;
            end
        end
        kb[3] = c;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            same = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < kn && KW_TEXT[k][i] != kb[i]) begin
                    same = 1'b0;
                end
            end
            if (same && kn == KW_LEN[k]) begin
                kw_hit  = 1'b1;
                kw_kind = KW_KIND[k];
            end
            if (same && kn < KW_LEN[k]) begin
                kw_pref = 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_pcnt     = r_pcnt;
        n_last     = r_last;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_ovf      = r_ovf;
        n_num_open = r_num_open;
        n_minus    = r_minus;
        n_buf      = r_buf;
        n_held     = r_held;
        n_log      = r_log;
        n_base     = r_base;
        n_prior    = r_prior;
        n_closed   = r_closed;
        n_mul_done = r_mul_done;
        n_ecnt     = r_ecnt;
        do_close   = 1'b0;
        finish     = 1'b0;
        emit       = 1'b0;
        e_kind     = TK_NUMBER;
        e_value    = '0;
        e_neg      = 1'b0;
        e_ovf      = 1'b0;
        e_uchar    = CH_NONE;
        e_last     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_pend[0] = i_char;
                    n_pcnt    = 3'd1;
                    n_last    = i_last;
                    n_ecnt    = 3'd0;
                    n_state   = ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (!i_q_full) begin
                    if (r_held != 2'd0) begin
                        if (kw_hit) begin
                            n_held = 2'd0;
                            if (kw_kind == TK_LOG) begin
                                n_log = 1'b1;
                            end else begin
                                emit   = 1'b1;
                                e_kind = kw_kind;
                            end
                            finish = 1'b1;
                        end else if (kw_pref) begin
                            n_buf[r_held] = c;
                            n_held        = r_held + 2'd1;
                            finish        = 1'b1;
                        end else begin
                            // first held letter is unknown, the rest go back in front of the pending characters
                            emit    = 1'b1;
                            e_kind  = TK_UNKNOWN;
                            e_uchar = r_buf[0];
                            n_held  = 2'd0;
                            for (int j = 0; j < 4; j++) begin
                                if (j < int'(h1)) begin
                                    n_pend[j] = r_buf[2'(j) + 2'd1];
                                end else begin
                                    n_pend[j] = r_pend[2'(j) - h1];
                                end
                            end
                            n_pcnt = r_pcnt + 3'(h1);
                        end
                    end else if (digit) begin
                        if (r_num_open || r_base) begin
                            n_mag = acc[VALUE_WIDTH-1:0];
                            n_ovf = r_ovf | acc[VALUE_WIDTH];
                        end else if (r_log) begin
                            n_log  = 1'b0;
                            n_base = 1'b1;
                            n_mag  = VALUE_WIDTH'(dval);
                            n_ovf  = 1'b0;
                        end else begin
                            if (r_minus) begin
                                n_neg   = 1'b1;
                                n_minus = 1'b0;
                            end else begin
                                n_neg = 1'b0;
                                if (r_prior == CH_RPAREN) begin
                                    emit   = 1'b1;
                                    e_kind = TK_MUL;
                                end
                            end
                            n_num_open = 1'b1;
                            n_mag      = VALUE_WIDTH'(dval);
                            n_ovf      = 1'b0;
                        end
                        finish = 1'b1;
                    end else if (close_any) begin
                        do_close = 1'b1;
                    end else begin
                        unique case (c) inside
                            CH_LPAREN: begin
                                if ((r_closed || r_prior == CH_RPAREN) && !r_mul_done) begin
                                    emit       = 1'b1;
                                    e_kind     = TK_MUL;
                                    n_mul_done = 1'b1;
                                end else begin
                                    emit   = 1'b1;
                                    e_kind = TK_LPAREN;
                                    finish = 1'b1;
                                end
                            end
                            CH_RPAREN: begin
                                emit   = 1'b1;
                                e_kind = TK_RPAREN;
                                finish = 1'b1;
                            end
                            CH_PLUS: begin
                                emit   = 1'b1;
                                e_kind = TK_PLUS;
                                finish = 1'b1;
                            end
                            CH_STAR: begin
                                emit   = 1'b1;
                                e_kind = TK_MUL;
                                finish = 1'b1;
                            end
                            CH_SLASH: begin
                                emit   = 1'b1;
                                e_kind = TK_DIV;
                                finish = 1'b1;
                            end
                            CH_CARET: begin
                                emit   = 1'b1;
                                e_kind = TK_POW;
                                finish = 1'b1;
                            end
                            CH_MINUS: begin
                                if (r_closed) begin
                                    emit   = 1'b1;
                                    e_kind = TK_MINUS;
                                end else begin
                                    n_minus = 1'b1;
                                end
                                finish = 1'b1;
                            end
                            [CH_TAB:CH_CR], CH_SPACE: begin
                                finish = 1'b1;
                            end
                            default: begin
                                if (is_kw_start(c)) begin
                                    n_buf[0] = c;
                                    n_held   = 2'd1;
                                end else begin
                                    emit    = 1'b1;
                                    e_kind  = TK_UNKNOWN;
                                    e_uchar = c;
                                end
                                finish = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_q_full) begin
                    if (close_any) begin
                        do_close = 1'b1;
                    end else if (r_held != 2'd0) begin
                        emit     = 1'b1;
                        e_kind   = TK_UNKNOWN;
                        e_uchar  = r_buf[0];
                        n_buf[0] = r_buf[1];
                        n_buf[1] = r_buf[2];
                        n_held   = r_held - 2'd1;
                    end else begin
                        emit       = 1'b1;
                        e_kind     = TK_END;
                        e_last     = 1'b1;
                        n_mag      = '0;
                        n_neg      = 1'b0;
                        n_ovf      = 1'b0;
                        n_prior    = CH_NONE;
                        n_closed   = 1'b0;
                        n_mul_done = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // pending sign, number, base and log close before anything else
        if (do_close) begin
            emit = 1'b1;
            if (r_minus) begin
                e_kind  = TK_MINUS;
                n_minus = 1'b0;
            end else if (r_num_open) begin
                e_kind     = TK_NUMBER;
                e_value    = r_mag;
                e_neg      = r_neg;
                e_ovf      = r_ovf;
                n_num_open = 1'b0;
                n_closed   = (r_state == ST_CHAR);
            end else if (r_base) begin
                e_kind  = TK_LOGBASE;
                e_value = r_mag;
                e_ovf   = r_ovf;
                n_base  = 1'b0;
            end else begin
                e_kind = TK_LOG;
                n_log  = 1'b0;
            end
        end

        if (finish) begin
            n_prior    = c;
            n_closed   = 1'b0;
            n_mul_done = 1'b0;
            n_pend[0]  = r_pend[1];
            n_pend[1]  = r_pend[2];
            n_pend[2]  = r_pend[3];
            n_pcnt     = r_pcnt - 3'd1;
            if (r_pcnt == 3'd1) begin
                n_state = r_last ? ST_FLUSH : ST_IDLE;
            end
        end

        if (o_push) begin
            n_ecnt = r_ecnt + 3'd1;
        end
    end

    // a word beyond the per-character budget is dropped
    assign o_push        = emit && (r_ecnt < MAX_RESULTS);
    assign o_token.kind  = e_kind;
    assign o_token.value = TOKEN_VALUE_W'(e_value);
    assign o_token.neg   = e_neg;
    assign o_token.ovf   = e_ovf;
    assign o_token.uchar = e_uchar;
    assign o_token.last  = e_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pcnt     <= 3'd0;
            r_last     <= 1'b0;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_ovf      <= 1'b0;
            r_num_open <= 1'b0;
            r_minus    <= 1'b0;
            r_held     <= 2'd0;
            r_log      <= 1'b0;
            r_base     <= 1'b0;
            r_prior    <= CH_NONE;
            r_closed   <= 1'b0;
            r_mul_done <= 1'b0;
            r_ecnt     <= 3'd0;
        end else begin
            r_state    <= n_state;
            r_pcnt     <= n_pcnt;
            r_last     <= n_last;
            r_mag      <= n_mag;
            r_neg      <= n_neg;
            r_ovf      <= n_ovf;
            r_num_open <= n_num_open;
            r_minus    <= n_minus;
            r_held     <= n_held;
            r_log      <= n_log;
            r_base     <= n_base;
            r_prior    <= n_prior;
            r_closed   <= n_closed;
            r_mul_done <= n_mul_done;
            r_ecnt     <= n_ecnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_buf  <= n_buf;
    end

`ifndef SYNTHESIS
    a_work_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHAR |-> (3'(r_held) + r_pcnt) <= 3'd4)
        else $error("held letters and pending characters exceed the work buffer");
    a_one_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_num_open && r_base))
        else $error("number and log base open together");
    a_end_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_token.last) |=> (r_state == ST_IDLE && r_held == 2'd0))
        else $error("lexer not back to idle after end word");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_pcnt == 3'd0)
        else $error("characters left pending while idle");
`endif

endmodule

### hdl/ael_queue.sv
// short token queue between the lexer front end and the output stage
module ael_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ael_pkg::t_token i_token,
    output logic            o_full,
    output logic            o_valid,
    output ael_pkg::t_token o_token,
    input  logic            i_pop
);
    import ael_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_token           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [PTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_token;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("word popped from an empty queue");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill level lost a word");
`endif

endmodule

### hdl/ael_back.sv
// output stage: registers one token word and packs it onto the master stream
module ael_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  ael_pkg::t_token                  i_token,
    output logic                             o_pop,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [ael_pkg::OUT_TDATA_W-1:0]  o_tdata,
    output logic [ael_pkg::KIND_W-1:0]       o_tuser,
    output logic                             o_tlast
);
    import ael_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - TOKEN_VALUE_W - 2 - CHAR_W;

    logic   r_valid;
    t_token r_tok;

    // refill when empty or when the held word leaves this cycle
    assign o_pop    = i_valid && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata  = {{PAD_W{1'b0}}, r_tok.uchar, r_tok.ovf, r_tok.neg, r_tok.value};
    assign o_tuser  = r_tok.kind;
    assign o_tlast  = r_tok.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tok <= i_token;
        end
    end

endmodule

### hdl/arithmetic_expression_lexer.sv
// top level of the streaming arithmetic expression lexer
// one character word is taken only when the lexer is idle; it then produces the tokens of that
// character and rescans any held letters, and it stalls while the token queue is full
// the end of an expression flushes each pending item and then produces the end token
// a token passes through the queue and the output register before it leaves on the master side
// synchronous active-low reset empties the queue and output register and clears the lexer
// state other than its pending-character and held-letter buffers
module arithmetic_expression_lexer #(
    parameter int VALUE_WIDTH = ael_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ael_pkg::CHAR_W-1:0]       s_axis_tdata,   // [7:0] char_code
    input  logic                             s_axis_tlast,   // last_char
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] number_value, [32] is_negative, [33] value_overflow, [41:34] unknown_char
    output logic [ael_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [ael_pkg::KIND_W-1:0]       m_axis_tuser,   // [4:0] token_kind
    output logic                             m_axis_tlast    // last_token
);
    import ael_pkg::*;

    logic   push;
    t_token push_tok;
    logic   q_full;
    logic   q_valid;
    t_token q_tok;
    logic   q_pop;

    ael_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_char   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_token  (push_tok)
    );

    ael_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (push_tok),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_token (q_tok),
        .i_pop   (q_pop)
    );

    ael_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_token  (q_tok),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
